/* hdl/cursor_array_list_engine_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cursor array list engine
// Shared property forms; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CURSOR_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CALE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cale assertion failed");

// Next-cycle implication, checked out of reset
`define CALE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cale assertion failed");

// Invariant, checked out of reset
`define CALE_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("cale assertion failed");

`endif

/* hdl/cale_pkg.sv */
// ----------------------------------------------------------------------------
// cale_pkg
// Types and constants of the cursor array list engine.
// ----------------------------------------------------------------------------
package cale_pkg;

	// List store geometry
	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int AW        = $clog2(DEPTH);
	localparam int LEN_BITS  = 5;
	localparam int CUR_BITS  = 6;
	localparam int OP_BITS   = 3;
	localparam int IDX_BITS  = 4;

	// Operation codes
	typedef enum logic [OP_BITS-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_START  = 3'd3,
		OP_END    = 3'd4,
		OP_PREV   = 3'd5,
		OP_NEXT   = 3'd6,
		OP_READ   = 3'd7
	} cale_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_RM_DATA,
		ST_RM_RD,
		ST_RM_WR
	} cale_state_t;

endpackage

/* hdl/cale_ram.sv */
// ----------------------------------------------------------------------------
// cale_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/cursor_array_list_engine_top.sv */
// Cursor moves and append register their result at acceptance; read goes through ST_READ.
// Insert walks ST_INS_RD and ST_INS_WR per moved entry, then ST_INS_PUT; remove walks ST_RM_DATA,
// then ST_RM_RD and ST_RM_WR per moved entry: each shifted entry costs one read and one write on
// the single list RAM port pair. busy stays high until the last cycle of the shift; one item is in
// work at a time. The result is strobed by done for one cycle; the receiver cannot stall.
// Reset clears length, cursor and the sequencer and sets the limit to 16; RAM is not cleared.
// ----------------------------------------------------------------------------
// cursor_array_list_engine_top
// Ordered list of signed words with a cursor, held in a RAM and shifted
// one entry at a time by a small sequencer.
// ----------------------------------------------------------------------------
`include "cursor_array_list_engine_top_assert.svh"

module cursor_array_list_engine_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cale_pkg::LEN_BITS-1:0]         cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [cale_pkg::OP_BITS-1:0]          op,
	input  logic signed [cale_pkg::WORD_BITS-1:0] value,
	input  logic [cale_pkg::IDX_BITS-1:0]         index,
	output logic                                  done,
	output logic signed [cale_pkg::WORD_BITS-1:0] data,
	output logic                                  ok,
	output logic [cale_pkg::LEN_BITS-1:0]         length,
	output logic signed [cale_pkg::CUR_BITS-1:0]  cursor
);

	import cale_pkg::*;

	cale_state_t                 state_q, state_d;
	logic [LEN_BITS-1:0]         cap_q;
	logic [LEN_BITS-1:0]         count_q, count_d;
	logic signed [CUR_BITS-1:0]  pos_q, pos_d;
	logic [AW-1:0]               ptr_q, ptr_d;
	logic [WORD_BITS-1:0]        val_q, val_d;
	logic                        done_q, done_d;
	logic                        ok_q, ok_d;
	logic [WORD_BITS-1:0]        data_q, data_d;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [WORD_BITS-1:0]        ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [WORD_BITS-1:0]        ram_rdata;

	logic [LEN_BITS-1:0]         limit;
	logic                        room;
	logic                        pos_neg;
	logic [LEN_BITS-1:0]         pos_u;
	logic                        accept;

	// List store
	cale_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Effective limit and cursor views
	assign limit   = (cap_q > LEN_BITS'(DEPTH)) ? LEN_BITS'(DEPTH) : cap_q;
	assign room    = count_q < limit;
	assign pos_neg = pos_q[CUR_BITS-1];
	assign pos_u   = pos_q[LEN_BITS-1:0];
	assign accept  = start && (state_q == ST_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= LEN_BITS'(DEPTH);
			count_q <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			count_q <= count_d;
			pos_q   <= pos_d;
			done_q  <= done_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		val_q  <= val_d;
		ok_q   <= ok_d;
		data_q <= data_d;
	end

	// Next state, datapath control and result
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		ptr_d     = ptr_q;
		val_d     = val_q;
		done_d    = 1'b0;
		ok_d      = ok_q;
		data_d    = data_q;
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = (cale_op_t'(op) == OP_READ) ? index : pos_q[AW-1:0];
				if (accept) begin
					done_d = 1'b1;
					ok_d   = 1'b1;
					data_d = '0;
					case (cale_op_t'(op))
						OP_APPEND: begin
							if (room) begin
								ram_we    = 1'b1;
								ram_waddr = count_q[AW-1:0];
								ram_wdata = value;
								count_d   = count_q + LEN_BITS'(1);
							end else begin
								ok_d = 1'b0;
							end
						end
						OP_INSERT: begin
							if (room && !pos_neg && (pos_u <= count_q)) begin
								done_d = 1'b0;
								val_d  = value;
								if (pos_u == count_q) begin
									state_d = ST_INS_PUT;
								end else begin
									ptr_d   = AW'(count_q - LEN_BITS'(1));
									state_d = ST_INS_RD;
								end
							end else begin
								ok_d = 1'b0;
							end
						end
						OP_REMOVE: begin
							if (!pos_neg && (pos_u < count_q)) begin
								done_d  = 1'b0;
								state_d = ST_RM_DATA;
							end else begin
								ok_d = 1'b0;
							end
						end
						OP_START: begin
							pos_d = '0;
						end
						OP_END: begin
							pos_d = $signed({1'b0, count_q}) - CUR_BITS'(1);
						end
						OP_PREV: begin
							if (pos_q > 0) begin
								pos_d = pos_q - CUR_BITS'(1);
							end else begin
								ok_d = 1'b0;
							end
						end
						OP_NEXT: begin
							if (pos_q < $signed({1'b0, count_q})) begin
								pos_d = pos_q + CUR_BITS'(1);
							end else begin
								ok_d = 1'b0;
							end
						end
						OP_READ: begin
							if ({1'b0, index} < count_q) begin
								done_d  = 1'b0;
								state_d = ST_READ;
							end else begin
								ok_d = 1'b0;
							end
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
					if (!ok_d) begin
						data_d = '1;
					end
				end
			end
			ST_READ: begin
				done_d  = 1'b1;
				data_d  = ram_rdata;
				state_d = ST_IDLE;
			end
			// Shift up: read entry ptr, write it to ptr + 1
			ST_INS_RD: begin
				ram_raddr = ptr_q;
				state_d   = ST_INS_WR;
			end
			ST_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + AW'(1);
				ram_wdata = ram_rdata;
				if (ptr_q == pos_q[AW-1:0]) begin
					state_d = ST_INS_PUT;
				end else begin
					ptr_d   = ptr_q - AW'(1);
					state_d = ST_INS_RD;
				end
			end
			ST_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = val_q;
				count_d   = count_q + LEN_BITS'(1);
				done_d    = 1'b1;
				data_d    = '0;
				state_d   = ST_IDLE;
			end
			// Hold the removed word, then shift down
			ST_RM_DATA: begin
				val_d = ram_rdata;
				if (pos_u + LEN_BITS'(1) == count_q) begin
					count_d = count_q - LEN_BITS'(1);
					done_d  = 1'b1;
					data_d  = ram_rdata;
					state_d = ST_IDLE;
				end else begin
					ptr_d   = pos_q[AW-1:0];
					state_d = ST_RM_RD;
				end
			end
			ST_RM_RD: begin
				ram_raddr = ptr_q + AW'(1);
				state_d   = ST_RM_WR;
			end
			ST_RM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
				if ({1'b0, ptr_q} + LEN_BITS'(2) == count_q) begin
					count_d = count_q - LEN_BITS'(1);
					done_d  = 1'b1;
					data_d  = val_q;
					state_d = ST_IDLE;
				end else begin
					ptr_d   = ptr_q + AW'(1);
					state_d = ST_RM_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Drive outputs
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign data   = data_q;
	assign ok     = ok_q;
	assign length = count_q;
	assign cursor = pos_q;

	// Checks
	`CALE_ASSERT_NXT(a_accept_answers, start && !busy, done || busy)
	`CALE_ASSERT_IMP(a_no_done_while_busy, busy, !done)
	`CALE_ASSERT_IMP(a_refused_all_ones, done && !ok, data == '1)
	`CALE_ASSERT_ALWAYS(a_length_in_range, length <= LEN_BITS'(DEPTH))
	`CALE_ASSERT_ALWAYS(a_cursor_in_range, (cursor >= -1) && (cursor <= $signed({1'b0, length})))

endmodule

/* tb/tb_cursor_array_list_engine_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_array_list_engine_top
// Drives list operations into the cursor array list engine and checks every
// result word against a local list model. Covers directed corner cases
// (empty list, full list, cursor out of range, lowered limit) and then
// random grow/shrink traffic under several capacity limits and idle rates.
// ----------------------------------------------------------------------------
module tb_cursor_array_list_engine_top;
	import cale_pkg::*;

	typedef struct {
		cale_op_t                    op;
		logic signed [WORD_BITS-1:0] value;
		logic [IDX_BITS-1:0]         index;
	} list_cmd_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] data;
		logic                        ok;
		logic [LEN_BITS-1:0]         length;
		logic signed [CUR_BITS-1:0]  cursor;
	} list_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [LEN_BITS-1:0]         cfg_data = '0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [OP_BITS-1:0]          op = '0;
	logic signed [WORD_BITS-1:0] value = '0;
	logic [IDX_BITS-1:0]         index = '0;
	logic                        done;
	logic signed [WORD_BITS-1:0] data;
	logic                        ok;
	logic [LEN_BITS-1:0]         length;
	logic signed [CUR_BITS-1:0]  cursor;

	// Local copy of the list state
	logic signed [WORD_BITS-1:0] list_cells [DEPTH];
	int                          list_len = 0;
	int                          list_pos = 0;
	logic [LEN_BITS-1:0]         list_limit = 5'd16;

	list_cmd_t    pending_cmds [$];
	list_result_t expected_words [$];
	list_cmd_t    cur_cmd;
	int           idle_pct = 35;
	int           mismatch_count = 0;

	cursor_array_list_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.value    (value),
		.index    (index),
		.done     (done),
		.data     (data),
		.ok       (ok),
		.length   (length),
		.cursor   (cursor)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one operation to the local list and return the result word
	function automatic list_result_t apply_list_op(list_cmd_t cmd);
		list_result_t res;
		int           lim;
		int           k;
		bit           good;
		lim = (list_limit > DEPTH) ? DEPTH : int'(list_limit);
		good = 1'b1;
		res.data = '0;
		case (cmd.op)
			OP_APPEND: begin
				if (list_len < lim) begin
					list_cells[list_len] = cmd.value;
					list_len++;
				end else begin
					good = 1'b0;
				end
			end
			OP_INSERT: begin
				if (list_len < lim && list_pos >= 0 && list_pos <= list_len) begin
					for (k = list_len; k > list_pos; k--)
						list_cells[k] = list_cells[k-1];
					list_cells[list_pos] = cmd.value;
					list_len++;
				end else begin
					good = 1'b0;
				end
			end
			OP_REMOVE: begin
				if (list_pos >= 0 && list_pos < list_len) begin
					res.data = list_cells[list_pos];
					for (k = list_pos; k < list_len - 1; k++)
						list_cells[k] = list_cells[k+1];
					list_len--;
				end else begin
					good = 1'b0;
				end
			end
			OP_START: list_pos = 0;
			OP_END:   list_pos = list_len - 1;
			OP_PREV: begin
				if (list_pos > 0)
					list_pos--;
				else
					good = 1'b0;
			end
			OP_NEXT: begin
				if (list_pos < list_len)
					list_pos++;
				else
					good = 1'b0;
			end
			default: begin
				if (int'(cmd.index) < list_len)
					res.data = list_cells[cmd.index];
				else
					good = 1'b0;
			end
		endcase
		if (!good)
			res.data = '1;
		res.ok = good;
		res.length = list_len[LEN_BITS-1:0];
		res.cursor = list_pos[CUR_BITS-1:0];
		return res;
	endfunction

	// Drive words from the pending queue; predict each one on acceptance
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				want = apply_list_op(cur_cmd);
				expected_words.push_back(want);
			end
			if (!start || !busy) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur_cmd = pending_cmds.pop_front();
					start <= 1'b1;
					op <= cur_cmd.op;
					value <= cur_cmd.value;
					index <= cur_cmd.index;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Compare each strobed result word with the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result data=%0d ok=%0b length=%0d cursor=%0d",
					$time, data, ok, length, cursor);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				if (data !== want.data) begin
					$display("%0t: data expected %0d actual %0d", $time, want.data, data);
					mismatch_count++;
				end
				if (ok !== want.ok) begin
					$display("%0t: ok expected %0b actual %0b", $time, want.ok, ok);
					mismatch_count++;
				end
				if (length !== want.length) begin
					$display("%0t: length expected %0d actual %0d", $time, want.length,
						length);
					mismatch_count++;
				end
				if (cursor !== want.cursor) begin
					$display("%0t: cursor expected %0d actual %0d", $time, want.cursor,
						cursor);
					mismatch_count++;
				end
			end
		end
	end

	task automatic push_cmd(cale_op_t o, logic signed [WORD_BITS-1:0] v,
		logic [IDX_BITS-1:0] ix);
		list_cmd_t cmd;
		cmd.op = o;
		cmd.value = v;
		cmd.index = ix;
		pending_cmds.push_back(cmd);
	endtask

	// Wait for every word to be accepted and answered and for the engine to leave busy
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || start || expected_words.size() != 0 || busy)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_limit(logic [LEN_BITS-1:0] lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= lim;
		list_limit = lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic in chunks of 32 that each grow or shrink the list, picked at random per chunk
	task automatic queue_random_ops(int n);
		logic signed [WORD_BITS-1:0] v;
		int                          pick;
		int                          j;
		bit                          grow;
		cale_op_t                    o;
		grow = 1'b1;
		for (j = 0; j < n; j++) begin
			if (j % 32 == 0)
				grow = $urandom_range(0, 2) != 0;
			pick = $urandom_range(0, 99);
			if (grow) begin
				if (pick < 30) o = OP_APPEND;
				else if (pick < 55) o = OP_INSERT;
				else if (pick < 63) o = OP_REMOVE;
				else if (pick < 70) o = OP_START;
				else if (pick < 76) o = OP_END;
				else if (pick < 82) o = OP_PREV;
				else if (pick < 90) o = OP_NEXT;
				else o = OP_READ;
			end else begin
				if (pick < 8) o = OP_APPEND;
				else if (pick < 16) o = OP_INSERT;
				else if (pick < 51) o = OP_REMOVE;
				else if (pick < 59) o = OP_START;
				else if (pick < 67) o = OP_END;
				else if (pick < 75) o = OP_PREV;
				else if (pick < 83) o = OP_NEXT;
				else o = OP_READ;
			end
			case ($urandom_range(0, 15))
				0:       v = 32'sh8000_0000;
				1:       v = 32'sh7fff_ffff;
				2:       v = '1;
				3:       v = '0;
				default: v = $urandom;
			endcase
			push_cmd(o, v, IDX_BITS'($urandom_range(0, 15)));
		end
	endtask

	task automatic run_phase(logic [LEN_BITS-1:0] lim, int pct, int n);
		wait_idle();
		write_limit(lim);
		idle_pct = pct;
		queue_random_ops(n);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, cursor at -1, insert at tail, edges of the cursor range
		idle_pct = 35;
		push_cmd(OP_REMOVE, 32'sd5, 4'd0);
		push_cmd(OP_READ, 32'sd0, 4'd0);
		push_cmd(OP_PREV, 32'sd0, 4'd0);
		push_cmd(OP_NEXT, 32'sd0, 4'd0);
		push_cmd(OP_END, 32'sd0, 4'd0);
		push_cmd(OP_INSERT, 32'sd9, 4'd0);
		push_cmd(OP_REMOVE, 32'sd0, 4'd0);
		push_cmd(OP_NEXT, 32'sd0, 4'd0);
		push_cmd(OP_APPEND, 32'sh7fff_ffff, 4'd0);
		push_cmd(OP_APPEND, 32'sh8000_0000, 4'd0);
		push_cmd(OP_INSERT, 32'sd0, 4'd0);
		push_cmd(OP_END, 32'sd0, 4'd0);
		push_cmd(OP_NEXT, 32'sd0, 4'd0);
		push_cmd(OP_INSERT, '1, 4'd0);
		push_cmd(OP_NEXT, 32'sd0, 4'd0);
		push_cmd(OP_NEXT, 32'sd0, 4'd0);
		push_cmd(OP_REMOVE, 32'sd0, 4'd0);
		push_cmd(OP_READ, 32'sd0, 4'd15);
		push_cmd(OP_READ, 32'sd0, 4'd3);
		push_cmd(OP_START, 32'sd0, 4'd0);
		push_cmd(OP_REMOVE, 32'sd0, 4'd0);
		push_cmd(OP_READ, 32'sd0, 4'd0);

		// Lower the limit below the current length
		wait_idle();
		write_limit(5'd2);
		push_cmd(OP_APPEND, 32'sd1, 4'd0);
		push_cmd(OP_REMOVE, 32'sd0, 4'd0);
		push_cmd(OP_APPEND, 32'sd2, 4'd0);
		push_cmd(OP_READ, 32'sd0, 4'd1);

		// Random traffic: sender idles at times, then often, then never
		run_phase(5'd31, 35, 150);
		run_phase(5'd4, 35, 100);
		run_phase(5'd16, 72, 150);
		run_phase(5'd0, 72, 50);
		run_phase(5'd1, 0, 100);
		run_phase(5'd9, 0, 100);
		run_phase(5'd16, 0, 150);

		wait_idle();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
